>>> hw/rtl/binary_max_heap_unit_defines.svh
// Assertion macros for the heap unit.
`ifndef BINARY_MAX_HEAP_UNIT_DEFINES_SVH
`define BINARY_MAX_HEAP_UNIT_DEFINES_SVH

// Checked on every rising clk edge outside reset.
`define BMH_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked on every rising clk edge, reset included.
`define BMH_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hw/rtl/bmh_pkg.sv
`timescale 1ns / 1ps

package bmh_pkg;

	// sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_UP_RD,
		ST_UP_CMP,
		ST_EX_RD,
		ST_EX_LD,
		ST_DN_RD,
		ST_DN_CMP,
		ST_DONE
	} state_t;

	localparam logic KIND_INSERT  = 1'b0;
	localparam logic KIND_EXTRACT = 1'b1;

	localparam int PORT_KEY_BITS   = 16;
	localparam int PORT_COUNT_BITS = 11;

endpackage

>>> hw/rtl/binary_max_heap_unit.sv
`timescale 1ns / 1ps
// Binary max-heap priority queue. A command is taken when start is high and busy is low:
// kind selects insert (key from insert_value) or extract of the largest key. Every command
// gives exactly one result, shown for a single cycle with done high; the receiver cannot
// stall, so it must capture the result in that cycle. An insert on a full heap is dropped
// and flagged by overflowed, an extract on an empty heap is flagged by was_empty; both
// show done in the first cycle after the transfer. Otherwise the key is sifted up or
// down, at most log2(HEAP_DEPTH) levels; an extract that leaves the heap empty does not
// sift. Each level costs a read state and a compare/write-back state, since the keys live
// in one synchronous memory with registered reads, and done is followed by an idle state
// before the next transfer. The memory has one write port and two read ports, so both
// children of a node are read together. No clearing pass is needed after reset: only
// keys in live slots are ever used.
`include "binary_max_heap_unit_defines.svh"

module binary_max_heap_unit #(
	parameter int HEAP_DEPTH = 1024,
	parameter int KEY_BITS   = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        kind,
	input  logic [15:0] insert_value,
	output logic        done,
	output logic [15:0] max_value,
	output logic        was_empty,
	output logic        overflowed,
	output logic [10:0] entries_held
);

	localparam int AW = (HEAP_DEPTH > 1) ? $clog2(HEAP_DEPTH) : 1;  // slot index
	localparam int CW = $clog2(HEAP_DEPTH + 1);                      // entry count
	localparam int KW = AW + 2;                                      // child index, widened
	localparam int XW = (KEY_BITS > bmh_pkg::PORT_KEY_BITS) ? KEY_BITS
	                                                        : bmh_pkg::PORT_KEY_BITS;

	// key storage: one write port, two registered read ports
	logic [KEY_BITS-1:0] mem [HEAP_DEPTH];
	logic                rd_en;
	logic [AW-1:0]       rd_addr_a, rd_addr_b;
	logic [KEY_BITS-1:0] rd_a, rd_b;
	logic                wr_en;
	logic [AW-1:0]       wr_addr;
	logic [KEY_BITS-1:0] wr_data;

	bmh_pkg::state_t     state_q, state_nx;
	logic [CW-1:0]       count_q;
	logic [AW-1:0]       pos_q;        // hole being filled
	logic [AW-1:0]       kid_q;        // left child of pos_q
	logic                right_ok_q;   // right child is live
	logic [KEY_BITS-1:0] key_q;        // key being sifted
	logic [15:0]         max_q;
	logic                empty_q, ovf_q;

	// command decode
	logic                accept;
	logic                full, empty;
	logic [XW-1:0]       in_ext;
	logic [KEY_BITS-1:0] key_in;

	assign accept = start && (state_q == bmh_pkg::ST_IDLE);
	assign full   = (count_q == CW'(HEAP_DEPTH));
	assign empty  = (count_q == '0);
	assign in_ext = XW'(insert_value);
	assign key_in = in_ext[KEY_BITS-1:0];

	// sift-up parent, sift-down children
	logic [AW-1:0] up_idx;
	logic [KW-1:0] kid_nx;
	logic [KW-1:0] count_ext;
	logic          left_ok_nx, right_ok_nx;
	logic          take_right;
	logic [KEY_BITS-1:0] child_key;
	logic [AW-1:0]       child_idx;

	assign up_idx      = (pos_q - AW'(1)) >> 1;
	assign kid_nx      = {1'b0, pos_q, 1'b1};
	assign count_ext   = KW'(count_q);
	assign left_ok_nx  = (kid_nx < count_ext);
	assign right_ok_nx = ((kid_nx + KW'(1)) < count_ext);
	// right child only when strictly larger; ties stay left
	assign take_right  = right_ok_q && (rd_b > rd_a);
	assign child_key   = take_right ? rd_b : rd_a;
	assign child_idx   = take_right ? (kid_q + AW'(1)) : kid_q;

	// next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			bmh_pkg::ST_IDLE: begin
				if (start) begin
					if (kind == bmh_pkg::KIND_INSERT)
						state_nx = full ? bmh_pkg::ST_DONE : bmh_pkg::ST_UP_RD;
					else
						state_nx = empty ? bmh_pkg::ST_DONE : bmh_pkg::ST_EX_RD;
				end
			end
			bmh_pkg::ST_UP_RD: begin
				state_nx = (pos_q == '0) ? bmh_pkg::ST_DONE : bmh_pkg::ST_UP_CMP;
			end
			bmh_pkg::ST_UP_CMP: begin
				state_nx = (rd_a < key_q) ? bmh_pkg::ST_UP_RD : bmh_pkg::ST_DONE;
			end
			bmh_pkg::ST_EX_RD: begin
				state_nx = bmh_pkg::ST_EX_LD;
			end
			bmh_pkg::ST_EX_LD: begin
				// last key removed: nothing to sift
				state_nx = empty ? bmh_pkg::ST_DONE : bmh_pkg::ST_DN_RD;
			end
			bmh_pkg::ST_DN_RD: begin
				state_nx = left_ok_nx ? bmh_pkg::ST_DN_CMP : bmh_pkg::ST_DONE;
			end
			bmh_pkg::ST_DN_CMP: begin
				state_nx = (child_key > key_q) ? bmh_pkg::ST_DN_RD : bmh_pkg::ST_DONE;
			end
			bmh_pkg::ST_DONE: begin
				state_nx = bmh_pkg::ST_IDLE;
			end
			default: begin
				state_nx = bmh_pkg::ST_IDLE;
			end
		endcase
	end

	// memory control
	always_comb begin
		rd_en     = 1'b0;
		rd_addr_a = '0;
		rd_addr_b = '0;
		wr_en     = 1'b0;
		wr_addr   = pos_q;
		wr_data   = key_q;
		case (state_q)
			bmh_pkg::ST_UP_RD: begin
				if (pos_q == '0) begin
					wr_en = 1'b1;   // reached the root
				end else begin
					rd_en     = 1'b1;
					rd_addr_a = up_idx;
				end
			end
			bmh_pkg::ST_UP_CMP: begin
				wr_en = 1'b1;
				if (rd_a < key_q)
					wr_data = rd_a;   // parent moves down into the hole
			end
			bmh_pkg::ST_EX_RD: begin
				// root and the last key (count already decremented)
				rd_en     = 1'b1;
				rd_addr_a = '0;
				rd_addr_b = count_q[AW-1:0];
			end
			bmh_pkg::ST_DN_RD: begin
				if (left_ok_nx) begin
					rd_en     = 1'b1;
					rd_addr_a = kid_nx[AW-1:0];
					rd_addr_b = kid_nx[AW-1:0] + AW'(1);
				end else begin
					wr_en = 1'b1;
				end
			end
			bmh_pkg::ST_DN_CMP: begin
				wr_en = 1'b1;
				if (child_key > key_q)
					wr_data = child_key;   // child moves up into the hole
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_a <= mem[rd_addr_a];
			rd_b <= mem[rd_addr_b];
		end
		if (wr_en)
			mem[wr_addr] <= wr_data;
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bmh_pkg::ST_IDLE;
			count_q <= '0;
		end else begin
			state_q <= state_nx;
			if (accept) begin
				if (kind == bmh_pkg::KIND_INSERT && !full)
					count_q <= count_q + CW'(1);
				else if (kind == bmh_pkg::KIND_EXTRACT && !empty)
					count_q <= count_q - CW'(1);
			end
		end
	end

	// datapath registers
	logic [XW-1:0] top_ext;
	assign top_ext = XW'(rd_a);

	always_ff @(posedge clk) begin
		case (state_q)
			bmh_pkg::ST_IDLE: begin
				if (start) begin
					pos_q   <= count_q[AW-1:0];   // new last slot
					key_q   <= key_in;
					max_q   <= '0;
					empty_q <= (kind == bmh_pkg::KIND_EXTRACT) && empty;
					ovf_q   <= (kind == bmh_pkg::KIND_INSERT) && full;
				end
			end
			bmh_pkg::ST_UP_CMP: begin
				if (rd_a < key_q)
					pos_q <= up_idx;
			end
			bmh_pkg::ST_EX_LD: begin
				max_q <= top_ext[15:0];
				key_q <= rd_b;
				pos_q <= '0;
			end
			bmh_pkg::ST_DN_RD: begin
				kid_q      <= kid_nx[AW-1:0];
				right_ok_q <= right_ok_nx;
			end
			bmh_pkg::ST_DN_CMP: begin
				if (child_key > key_q)
					pos_q <= child_idx;
			end
			default: begin
			end
		endcase
	end

	// outputs
	assign busy         = (state_q != bmh_pkg::ST_IDLE);
	assign done         = (state_q == bmh_pkg::ST_DONE);
	assign max_value    = max_q;
	assign was_empty    = empty_q;
	assign overflowed   = ovf_q;
	assign entries_held = bmh_pkg::PORT_COUNT_BITS'(count_q);

	`BMH_ASSERT_ALWAYS(a_count_range, count_q <= CW'(HEAP_DEPTH), "entry count beyond depth")
	`BMH_ASSERT(a_wr_live, wr_en |-> (CW'(wr_addr) < count_q), "write outside live slots")
	`BMH_ASSERT(a_empty_res, done && was_empty |-> empty && !overflowed && max_q == '0, "bad empty")
	`BMH_ASSERT(a_ovf_res, done && overflowed |-> full && (max_q == '0), "bad overflow result")
	`BMH_ASSERT(a_take_busy, accept |=> busy, "command taken but not busy")

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

	localparam int HEAP_DEPTH  = 1024;
	localparam int STALL_LIMIT = 2000; // well above the worst op plus the longest sender gap
	localparam int DRAIN_CYCLES = 40;

	// one result as seen on the result ports
	typedef struct packed {
		logic [bmh_pkg::PORT_KEY_BITS-1:0]   max_value;
		logic                                was_empty;
		logic                                overflowed;
		logic [bmh_pkg::PORT_COUNT_BITS-1:0] entries_held;
	} heap_result_t;

	// directed row: typed == 1 means the expected result is written out here,
	// otherwise the heap predictor supplies it
	typedef struct packed {
		logic                              op_kind;
		logic [bmh_pkg::PORT_KEY_BITS-1:0] key;
		logic                              typed;
		heap_result_t                      want;
	} heap_row_t;

	localparam heap_result_t NOT_TYPED = '0;
	localparam int DIR_ROWS = 24;

	localparam heap_row_t dir_rows [DIR_ROWS] = '{
		// extract right after reset: empty flag
		'{bmh_pkg::KIND_EXTRACT, 16'hFFFF, 1'b1, '{16'h0000, 1'b1, 1'b0, 11'd0}},
		// key 0 goes in and comes back out, not to be confused with empty
		'{bmh_pkg::KIND_INSERT,  16'h0000, 1'b1, '{16'h0000, 1'b0, 1'b0, 11'd1}},
		'{bmh_pkg::KIND_EXTRACT, 16'hFFFF, 1'b1, '{16'h0000, 1'b0, 1'b0, 11'd0}},
		'{bmh_pkg::KIND_INSERT,  16'hFFFF, 1'b1, '{16'h0000, 1'b0, 1'b0, 11'd1}},
		// equal top keys, then a spread of bit patterns
		'{bmh_pkg::KIND_INSERT,  16'hFFFF, 1'b0, NOT_TYPED},
		'{bmh_pkg::KIND_INSERT,  16'h0000, 1'b0, NOT_TYPED},
		'{bmh_pkg::KIND_INSERT,  16'h8000, 1'b0, NOT_TYPED},
		'{bmh_pkg::KIND_INSERT,  16'h7FFF, 1'b0, NOT_TYPED},
		'{bmh_pkg::KIND_INSERT,  16'hAAAA, 1'b0, NOT_TYPED},
		'{bmh_pkg::KIND_INSERT,  16'h5555, 1'b0, NOT_TYPED},
		'{bmh_pkg::KIND_INSERT,  16'h0001, 1'b0, NOT_TYPED},
		'{bmh_pkg::KIND_INSERT,  16'h8000, 1'b0, NOT_TYPED},
		'{bmh_pkg::KIND_INSERT,  16'h0000, 1'b0, NOT_TYPED},
		// both copies of the max leave first
		'{bmh_pkg::KIND_EXTRACT, 16'h0000, 1'b1, '{16'hFFFF, 1'b0, 1'b0, 11'd9}},
		'{bmh_pkg::KIND_EXTRACT, 16'hFFFF, 1'b1, '{16'hFFFF, 1'b0, 1'b0, 11'd8}},
		'{bmh_pkg::KIND_EXTRACT, 16'h0000, 1'b0, NOT_TYPED},
		'{bmh_pkg::KIND_EXTRACT, 16'hFFFF, 1'b0, NOT_TYPED},
		'{bmh_pkg::KIND_EXTRACT, 16'h0000, 1'b0, NOT_TYPED},
		'{bmh_pkg::KIND_EXTRACT, 16'hFFFF, 1'b0, NOT_TYPED},
		'{bmh_pkg::KIND_EXTRACT, 16'h0000, 1'b0, NOT_TYPED},
		'{bmh_pkg::KIND_EXTRACT, 16'hFFFF, 1'b0, NOT_TYPED},
		'{bmh_pkg::KIND_EXTRACT, 16'h0000, 1'b0, NOT_TYPED},
		'{bmh_pkg::KIND_EXTRACT, 16'hFFFF, 1'b0, NOT_TYPED},
		// drained again
		'{bmh_pkg::KIND_EXTRACT, 16'h0000, 1'b1, '{16'h0000, 1'b1, 1'b0, 11'd0}}
	};

	logic                                clk;
	logic                                arst_n;
	logic                                start;
	logic                                busy;
	logic                                kind;
	logic [bmh_pkg::PORT_KEY_BITS-1:0]   insert_value;
	logic                                done;
	logic [bmh_pkg::PORT_KEY_BITS-1:0]   max_value;
	logic                                was_empty;
	logic                                overflowed;
	logic [bmh_pkg::PORT_COUNT_BITS-1:0] entries_held;

	// heap mirror and results still owed by the unit
	logic [bmh_pkg::PORT_KEY_BITS-1:0] heap_keys [HEAP_DEPTH];
	int                                key_count;
	heap_result_t                      heap_results_due [$];
	heap_result_t                      oldest_due;
	int                                mismatch_count;
	int                                idle_cycles;
	bit                                no_idle;

	binary_max_heap_unit #(
		.HEAP_DEPTH(HEAP_DEPTH),
		.KEY_BITS  (bmh_pkg::PORT_KEY_BITS)
	) uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.kind        (kind),
		.insert_value(insert_value),
		.done        (done),
		.max_value   (max_value),
		.was_empty   (was_empty),
		.overflowed  (overflowed),
		.entries_held(entries_held)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	task automatic report_mismatch(input string msg);
		$display("[%0t] %s", $time, msg);
		mismatch_count++;
	endtask

	// Apply one operation to the mirror and give the result it should produce.
	// Insert: sift up while the parent is strictly smaller.
	// Extract: last key to the root, sift down; right child only if strictly
	// larger than the left, move only while the child is strictly larger.
	task automatic apply_heap_op(input logic op_kind,
			input logic [bmh_pkg::PORT_KEY_BITS-1:0] key,
			output heap_result_t res);
		int pos;
		int up;
		int kid;
		logic [bmh_pkg::PORT_KEY_BITS-1:0] moved;
		res = '0;
		if (op_kind == bmh_pkg::KIND_INSERT) begin
			if (key_count >= HEAP_DEPTH) begin
				res.overflowed = 1'b1;
			end else begin
				pos = key_count;
				while (pos > 0) begin
					up = (pos - 1) / 2;
					if (heap_keys[up] < key) begin
						heap_keys[pos] = heap_keys[up];
						pos = up;
					end else begin
						break;
					end
				end
				heap_keys[pos] = key;
				key_count++;
			end
		end else if (key_count == 0) begin
			res.was_empty = 1'b1;
		end else begin
			res.max_value = heap_keys[0];
			key_count--;
			moved = heap_keys[key_count];
			pos = 0;
			while (1) begin
				kid = 2 * pos + 1;
				if (kid >= key_count)
					break;
				if (kid + 1 < key_count && heap_keys[kid + 1] > heap_keys[kid])
					kid++;
				if (heap_keys[kid] > moved) begin
					heap_keys[pos] = heap_keys[kid];
					pos = kid;
				end else begin
					break;
				end
			end
			heap_keys[pos] = moved;
		end
		res.entries_held = key_count[bmh_pkg::PORT_COUNT_BITS-1:0];
	endtask

	// Mostly back-to-back or short gaps, now and then a long one; no gaps at
	// all while a burst stretch is on.
	function automatic int pick_gap();
		int roll;
		if (no_idle)
			return 0;
		roll = $urandom_range(0, 99);
		if (roll < 40)
			return 0;
		if (roll < 85)
			return $urandom_range(1, 3);
		if (roll < 96)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Present one command and hold it until the transfer. start is left high
	// afterwards so a zero gap keeps it high without a lower/raise in one step.
	task automatic send_op(input logic op_kind,
			input logic [bmh_pkg::PORT_KEY_BITS-1:0] key,
			input logic typed, input heap_result_t want, input int gap);
		heap_result_t predicted;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start        <= 1'b1;
		kind         <= op_kind;
		insert_value <= key;
		do
			@(posedge clk);
		while (busy);
		apply_heap_op(op_kind, key, predicted);
		heap_results_due.push_back(typed ? want : predicted);
	endtask

	// Random commands; insert_pct steers the fill level. Keys favor the
	// extremes and a narrow low band so ties are common.
	task automatic random_ops(input int count, input int insert_pct);
		logic [bmh_pkg::PORT_KEY_BITS-1:0] key;
		logic                              op_kind;
		for (int n = 0; n < count; n++) begin
			if (n % 50 == 0)
				no_idle = ($urandom_range(0, 3) == 0);
			case ($urandom_range(0, 7))
				0: key = '0;
				1: key = '1;
				2, 3: key = bmh_pkg::PORT_KEY_BITS'($urandom_range(0, 15));
				4: key = bmh_pkg::PORT_KEY_BITS'(32'hFFF0 | $urandom_range(0, 15));
				default: key = bmh_pkg::PORT_KEY_BITS'($urandom);
			endcase
			op_kind = ($urandom_range(0, 99) < insert_pct) ? bmh_pkg::KIND_INSERT
			                                               : bmh_pkg::KIND_EXTRACT;
			send_op(op_kind, key, 1'b0, NOT_TYPED, pick_gap());
		end
	endtask

	// result checker: the unit cannot be stalled, so every done cycle is a transfer
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (heap_results_due.size() == 0) begin
				report_mismatch($sformatf("unexpected result max_value=%h held=%0d",
					max_value, entries_held));
			end else begin
				oldest_due = heap_results_due.pop_front();
				if (max_value !== oldest_due.max_value)
					report_mismatch($sformatf("max_value %h, want %h",
						max_value, oldest_due.max_value));
				if (was_empty !== oldest_due.was_empty)
					report_mismatch($sformatf("was_empty %b, want %b",
						was_empty, oldest_due.was_empty));
				if (overflowed !== oldest_due.overflowed)
					report_mismatch($sformatf("overflowed %b, want %b",
						overflowed, oldest_due.overflowed));
				if (entries_held !== oldest_due.entries_held)
					report_mismatch($sformatf("entries_held %0d, want %0d",
						entries_held, oldest_due.entries_held));
			end
		end
	end

	// watchdog: cycles with neither a command transfer nor a result
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("[%0t] no transfer for %0d cycles", $time, STALL_LIMIT);
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	initial begin
		clk            = 1'b0;
		arst_n        <= 1'b0;
		start         <= 1'b0;
		kind          <= bmh_pkg::KIND_INSERT;
		insert_value  <= '0;
		key_count      = 0;
		mismatch_count = 0;
		idle_cycles    = 0;
		no_idle        = 1'b0;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty, key 0, extremes, ties, drain
		for (int i = 0; i < DIR_ROWS; i++)
			send_op(dir_rows[i].op_kind, dir_rows[i].key, dir_rows[i].typed,
				dir_rows[i].want, pick_gap());

		// hover near empty: frequent empty extracts, shallow heaps
		random_ops(400, 50);
		// fill to capacity, then sit at full so inserts get dropped
		while (key_count < HEAP_DEPTH)
			random_ops(1, 97);
		random_ops(40, 75);
		// deep heap drains: long sift-down paths
		random_ops(400, 15);

		start <= 1'b0;
		while (heap_results_due.size() > 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatch_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

>>> binary_max_heap_unit.f
+incdir+hw/rtl
hw/rtl/bmh_pkg.sv
hw/rtl/binary_max_heap_unit.sv
tb/sv/tb_top.sv
